// ----- hdl/rgbhsv_pkg.sv -----
`default_nettype none
package rgbhsv_pkg;

    localparam int unsigned PIX_W = 8;
    // Width of a long-division dividend: 255 * span needs sixteen bits.
    localparam int unsigned NUM_W = 2 * PIX_W;
    // One quotient bit is resolved per divider stage.
    localparam int unsigned DIV_STAGES = PIX_W;

    localparam logic [PIX_W-1:0] FULL_SCALE    = 8'd255;
    localparam logic [PIX_W-1:0] HUE_SCALE     = 8'd43;
    localparam logic [PIX_W-1:0] HUE_OFS_RED   = 8'd0;
    localparam logic [PIX_W-1:0] HUE_OFS_GREEN = 8'd85;
    localparam logic [PIX_W-1:0] HUE_OFS_BLUE  = 8'd171;

    typedef logic [PIX_W-1:0] t_pix;

    // State of one restoring divider lane. The partial remainder sits in rem,
    // acc holds the dividend bits still to be shifted in at its top and
    // collects quotient bits at its bottom.
    typedef struct packed {
        t_pix rem;
        t_pix acc;
        t_pix den;
    } t_div_lane;

    // Data that travels beside the dividers to the final stage.
    typedef struct packed {
        logic neg;
        t_pix offset;
        t_pix value;
        logic grey;
    } t_side;

endpackage
`default_nettype wire

// ----- hdl/rgbhsv_if.sv -----
`default_nettype none
interface rgbhsv_pix_if;
    logic               valid;
    logic               ready;
    rgbhsv_pkg::t_pix   red;
    rgbhsv_pkg::t_pix   green;
    rgbhsv_pkg::t_pix   blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if;
    logic               valid;
    logic               ready;
    rgbhsv_pkg::t_pix   hue;
    rgbhsv_pkg::t_pix   saturation;
    rgbhsv_pkg::t_pix   brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface
`default_nettype wire

// ----- hdl/rgbhsv_front.sv -----
`default_nettype none
module rgbhsv_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_ce,
    input  wire logic                   i_valid,
    input  wire rgbhsv_pkg::t_pix       i_red,
    input  wire rgbhsv_pkg::t_pix       i_green,
    input  wire rgbhsv_pkg::t_pix       i_blue,
    output logic                        o_valid,
    output rgbhsv_pkg::t_div_lane       o_sat,
    output rgbhsv_pkg::t_div_lane       o_hue,
    output rgbhsv_pkg::t_side           o_side
);

    // First stage registers.
    logic               r_valid1;
    rgbhsv_pkg::t_pix   r_hi;
    rgbhsv_pkg::t_pix   r_lo;
    rgbhsv_pkg::t_pix   r_absd;
    logic               r_neg;
    rgbhsv_pkg::t_pix   r_offset;

    rgbhsv_pkg::t_pix   n_hi;
    rgbhsv_pkg::t_pix   n_lo;
    rgbhsv_pkg::t_pix   n_absd;
    logic               n_neg;
    rgbhsv_pkg::t_pix   n_offset;

    // Second stage registers.
    logic                   r_valid2;
    rgbhsv_pkg::t_div_lane  r_sat;
    rgbhsv_pkg::t_div_lane  r_hue;
    rgbhsv_pkg::t_side      r_side;

    rgbhsv_pkg::t_pix                   span;
    logic [rgbhsv_pkg::NUM_W-1:0]       sat_num;
    logic [rgbhsv_pkg::NUM_W-1:0]       hue_num;
    rgbhsv_pkg::t_div_lane              n_sat;
    rgbhsv_pkg::t_div_lane              n_hue;
    rgbhsv_pkg::t_side                  n_side;

    // Largest and smallest channel, and the magnitude and sign of the
    // difference of the other two. Ties go to red, then to green.
    always_comb begin
        rgbhsv_pkg::t_pix a;
        rgbhsv_pkg::t_pix b;
        n_hi = (i_red > i_green) ? i_red : i_green;
        if (i_blue > n_hi) begin
            n_hi = i_blue;
        end
        n_lo = (i_red < i_green) ? i_red : i_green;
        if (i_blue < n_lo) begin
            n_lo = i_blue;
        end
        if (n_hi == i_red) begin
            a        = i_green;
            b        = i_blue;
            n_offset = rgbhsv_pkg::HUE_OFS_RED;
        end else if (n_hi == i_green) begin
            a        = i_blue;
            b        = i_red;
            n_offset = rgbhsv_pkg::HUE_OFS_GREEN;
        end else begin
            a        = i_red;
            b        = i_green;
            n_offset = rgbhsv_pkg::HUE_OFS_BLUE;
        end
        n_neg  = (a < b);
        n_absd = n_neg ? (b - a) : (a - b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else if (i_ce) begin
            r_valid1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_hi     <= n_hi;
            r_lo     <= n_lo;
            r_absd   <= n_absd;
            r_neg    <= n_neg;
            r_offset <= n_offset;
        end
    end

    // Dividends for both divisions and the initial divider state. The
    // saturation dividend 255 * span is formed as span * 256 - span.
    always_comb begin
        span    = r_hi - r_lo;
        sat_num = {span, rgbhsv_pkg::PIX_W'(0)} - {rgbhsv_pkg::PIX_W'(0), span};
        hue_num = rgbhsv_pkg::NUM_W'(r_absd) * rgbhsv_pkg::NUM_W'(rgbhsv_pkg::HUE_SCALE);

        n_sat.rem = sat_num[rgbhsv_pkg::NUM_W-1:rgbhsv_pkg::PIX_W];
        n_sat.acc = sat_num[rgbhsv_pkg::PIX_W-1:0];
        n_sat.den = r_hi;

        n_hue.rem = hue_num[rgbhsv_pkg::NUM_W-1:rgbhsv_pkg::PIX_W];
        n_hue.acc = hue_num[rgbhsv_pkg::PIX_W-1:0];
        n_hue.den = span;

        n_side.neg    = r_neg;
        n_side.offset = r_offset;
        n_side.value  = r_hi;
        n_side.grey   = (span == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
        end else if (i_ce) begin
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sat  <= n_sat;
            r_hue  <= n_hue;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid2;
    assign o_sat   = r_sat;
    assign o_hue   = r_hue;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// ----- hdl/rgbhsv_div_stage.sv -----
`default_nettype none
module rgbhsv_div_stage (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_ce,
    input  wire logic                   i_valid,
    input  wire rgbhsv_pkg::t_div_lane  i_sat,
    input  wire rgbhsv_pkg::t_div_lane  i_hue,
    input  wire rgbhsv_pkg::t_side      i_side,
    output logic                        o_valid,
    output rgbhsv_pkg::t_div_lane       o_sat,
    output rgbhsv_pkg::t_div_lane       o_hue,
    output rgbhsv_pkg::t_side           o_side
);

    logic                   r_valid;
    rgbhsv_pkg::t_div_lane  r_sat;
    rgbhsv_pkg::t_div_lane  r_hue;
    rgbhsv_pkg::t_side      r_side;

    rgbhsv_pkg::t_div_lane  n_sat;
    rgbhsv_pkg::t_div_lane  n_hue;

    // One restoring step: shift the next dividend bit into the remainder,
    // subtract the divisor when it fits and shift the quotient bit in.
    function automatic rgbhsv_pkg::t_div_lane div_step(input rgbhsv_pkg::t_div_lane s);
        logic [rgbhsv_pkg::PIX_W:0]     t;
        logic [rgbhsv_pkg::PIX_W:0]     d;
        logic                           fits;
        rgbhsv_pkg::t_div_lane          r;
        t      = {s.rem, s.acc[rgbhsv_pkg::PIX_W-1]};
        d      = t - {1'b0, s.den};
        fits   = (t >= {1'b0, s.den});
        r.rem  = fits ? d[rgbhsv_pkg::PIX_W-1:0] : t[rgbhsv_pkg::PIX_W-1:0];
        r.acc  = {s.acc[rgbhsv_pkg::PIX_W-2:0], fits};
        r.den  = s.den;
        return r;
    endfunction

    always_comb begin
        n_sat = div_step(i_sat);
        n_hue = div_step(i_hue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sat  <= n_sat;
            r_hue  <= n_hue;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_sat   = r_sat;
    assign o_hue   = r_hue;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// ----- hdl/rgbhsv_back.sv -----
`default_nettype none
module rgbhsv_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_ce,
    input  wire logic                   i_valid,
    input  wire rgbhsv_pkg::t_div_lane  i_sat,
    input  wire rgbhsv_pkg::t_div_lane  i_hue,
    input  wire rgbhsv_pkg::t_side      i_side,
    output logic                        o_valid,
    output rgbhsv_pkg::t_pix            o_hue,
    output rgbhsv_pkg::t_pix            o_saturation,
    output rgbhsv_pkg::t_pix            o_brightness
);

    logic               r_valid;
    rgbhsv_pkg::t_pix   r_hue;
    rgbhsv_pkg::t_pix   r_sat;
    rgbhsv_pkg::t_pix   r_val;

    rgbhsv_pkg::t_pix   n_hue;
    rgbhsv_pkg::t_pix   n_sat;
    rgbhsv_pkg::t_pix   hue_q;

    // Apply the sign to the hue quotient and add the sector offset; the
    // sum wraps naturally in eight bits. Grey and black pixels force zero.
    always_comb begin
        hue_q = i_side.neg ? (rgbhsv_pkg::PIX_W'(0) - i_hue.acc) : i_hue.acc;
        n_hue = i_side.grey ? '0 : (i_side.offset + hue_q);
        n_sat = (i_side.value == '0) ? '0 : i_sat.acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= i_side.value;
        end
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_val;

endmodule
`default_nettype wire

// ----- hdl/rgb_to_hsv_8bit_core.sv -----
`default_nettype none
// Converts a stream of 8-bit RGB pixels to 8-bit hue, saturation and value,
// one pixel per clock unless stalled. The pipeline is eleven stages deep: two
// front stages find the largest and smallest channel and form the dividends,
// eight stages run two restoring dividers side by side (saturation and hue),
// one quotient bit per stage, and a final stage adds the hue offset and writes
// the output register. The whole pipeline advances whenever the output
// register is empty or being taken; input ready is this same advance
// condition, and a stall holds every stage in place.
module rgb_to_hsv_8bit_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rgbhsv_pix_if.sink      i_pix,
    rgbhsv_hsv_if.source    o_hsv
);

    localparam int unsigned NSTG = rgbhsv_pkg::DIV_STAGES;

    logic                   ce;
    logic                   out_valid;

    logic                   stg_valid [NSTG+1];
    rgbhsv_pkg::t_div_lane  stg_sat   [NSTG+1];
    rgbhsv_pkg::t_div_lane  stg_hue   [NSTG+1];
    rgbhsv_pkg::t_side      stg_side  [NSTG+1];

    // Advance everything unless a finished item is waiting and not taken.
    assign ce          = !out_valid || o_hsv.ready;
    assign i_pix.ready = ce;
    assign o_hsv.valid = out_valid;

    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_pix.valid),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (stg_valid[0]),
        .o_sat   (stg_sat[0]),
        .o_hue   (stg_hue[0]),
        .o_side  (stg_side[0])
    );

    // Divider stages, one quotient bit each.
    for (genvar k = 0; k < NSTG; k++) begin : g_div
        rgbhsv_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (stg_valid[k]),
            .i_sat   (stg_sat[k]),
            .i_hue   (stg_hue[k]),
            .i_side  (stg_side[k]),
            .o_valid (stg_valid[k+1]),
            .o_sat   (stg_sat[k+1]),
            .o_hue   (stg_hue[k+1]),
            .o_side  (stg_side[k+1])
        );
    end

    rgbhsv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ce         (ce),
        .i_valid      (stg_valid[NSTG]),
        .i_sat        (stg_sat[NSTG]),
        .i_hue        (stg_hue[NSTG]),
        .i_side       (stg_side[NSTG]),
        .o_valid      (out_valid),
        .o_hue        (o_hsv.hue),
        .o_saturation (o_hsv.saturation),
        .o_brightness (o_hsv.brightness)
    );

endmodule
`default_nettype wire
